FILE: rtl/ctq_pkg.sv
// ctq_pkg: shared types and constants for the connection timeout queue.
// Used by ctq_cell, ctq_result_buf and connection_timeout_queue.
// No dependencies.

package ctq_pkg;

    localparam int ExpW   = 32;
    localparam int ConnW  = 10;
    localparam int SeqW   = 32;
    localparam int WaitW  = 16;
    localparam int CountW = 7;
    localparam int MaxRes = 64;
    localparam int ResAw  = 6;

    // input mode codes
    localparam logic [1:0] ModeAdd    = 2'd0;
    localparam logic [1:0] ModeDelete = 2'd1;
    localparam logic [1:0] ModePoll   = 2'd2;
    localparam logic [1:0] ModeClear  = 2'd3;

    // configuration register indexes
    localparam logic CfgWaitTime = 1'b0;
    localparam logic CfgKick     = 1'b1;

    localparam logic [WaitW-1:0] WaitTimeReset = 16'd30;

    typedef struct packed {
        logic [ExpW-1:0]  expiry;
        logic [ConnW-1:0] conn;
        logic [SeqW-1:0]  seq;
    } entry_t;

    // what a cell holds
    typedef struct packed {
        logic   used;
        entry_t ent;
    } cell_state_t;

    // a cell's view for this cycle, handed to its right neighbor
    typedef struct packed {
        logic   used;
        logic   gt;
        entry_t ent;
    } cell_link_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic            shift;
        logic            ins;
        logic            cmp_en;
        logic [ExpW-1:0] key;
        entry_t          data;
    } cell_op_t;

    typedef struct packed {
        logic [ConnW-1:0] conn;
        logic [SeqW-1:0]  seq;
    } res_t;

endpackage

FILE: rtl/ctq_cell.sv
// ctq_cell: one slot of the sorted timer chain.
// Takes from its right neighbor on a shift and makes room for an insert.
// Depends on ctq_pkg.

module ctq_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctq_pkg::cell_op_t    op,
    input  logic                 clear_all,
    input  ctq_pkg::cell_link_t  left,
    input  ctq_pkg::cell_state_t right,
    output ctq_pkg::cell_state_t state,
    output ctq_pkg::cell_link_t  link
);

    ctq_pkg::entry_t      ent_reg;
    ctq_pkg::entry_t      ent_next;
    logic                 used_reg;
    logic                 used_next;
    ctq_pkg::cell_state_t view;
    logic                 gt;

    // view after the optional head pop
    always_comb
    begin
        if (op.shift)
        begin
            view = right;
        end
        else
        begin
            view.used = used_reg;
            view.ent  = ent_reg;
        end
    end

    assign gt = op.cmp_en && view.used && (view.ent.expiry > op.key);

    assign link.used = view.used;
    assign link.gt   = gt;
    assign link.ent  = view.ent;

    always_comb
    begin
        ent_next  = view.ent;
        used_next = view.used;
        if (clear_all)
        begin
            used_next = 1'b0;
        end
        else if (op.ins && left.gt)
        begin
            // left neighbor moves right to make room
            ent_next  = left.ent;
            used_next = 1'b1;
        end
        else if (op.ins && (gt || !view.used) && left.used)
        begin
            ent_next  = op.data;
            used_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign state.used = used_reg;
    assign state.ent  = ent_reg;

endmodule

FILE: rtl/ctq_result_buf.sv
// ctq_result_buf: holds the entries popped by one poll until they are sent.
// Single write port, registered read. Depends on ctq_pkg.

module ctq_result_buf
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ctq_pkg::ResAw-1:0]  wr_addr,
    input  ctq_pkg::res_t              wr_data,
    input  logic                       rd_en,
    input  logic [ctq_pkg::ResAw-1:0]  rd_addr,
    output ctq_pkg::res_t              rd_data
);

    ctq_pkg::res_t mem [ctq_pkg::MaxRes];
    ctq_pkg::res_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/connection_timeout_queue.sv
// connection_timeout_queue: connection timers sorted by expiry in a row of cells.
// Top level; depends on ctq_pkg, ctq_cell and ctq_result_buf.
//
// Usage:
//   Input beats (mode, conn_id, seq_num, now_time) are taken on in_valid with
//   in_stall low. in_stall is high while an item is being worked on or its
//   results are still being handed out; one item is worked on at a time.
//   Result beats leave on out_valid/out_stall through an output register; the
//   final beat of an item has last set. entry_count and earliest_expiry give
//   the state once the whole item is done.
//   An add or clear acts on the chain once and then loads its single beat; a
//   delete rotates the whole store through the chain, one entry per cycle,
//   and a poll pops due entries into the result buffer, one per cycle, then
//   reads each back from the buffer to load it as a result beat.
//   The next item is taken while the last result still sits in the output
//   register.
//   Stalls on the output hold the register and stop the result sweep.
//   Reset empties the store at once (per-cell valid bits), sets wait_time to
//   30 and kick_on_timeout to 0. Config writes (cfg_wr_en, cfg_index, cfg_data)
//   take effect at the next edge; the user must make them while idle (unchecked).

module connection_timeout_queue
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int CONN_BITS   = 10
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [ctq_pkg::WaitW-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic [ctq_pkg::ConnW-1:0]    conn_id,
    input  logic [ctq_pkg::SeqW-1:0]     seq_num,
    input  logic [ctq_pkg::ExpW-1:0]     now_time,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         expired_valid,
    output logic [ctq_pkg::ConnW-1:0]    expired_conn,
    output logic [ctq_pkg::SeqW-1:0]     expired_seq,
    output logic                         status,
    output logic [ctq_pkg::CountW-1:0]   removed_count,
    output logic [ctq_pkg::CountW-1:0]   entry_count,
    output logic [ctq_pkg::ExpW-1:0]     earliest_expiry,
    output logic                         last
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam int ExtW = CntW + ctq_pkg::CountW;
    localparam logic [32:0] ConnMaskFull = (33'd1 << CONN_BITS) - 33'd1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_DEL   = 6'b000100,
        S_POLL  = 6'b001000,
        S_FETCH = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [ctq_pkg::WaitW-1:0] wait_time_reg;
    logic                      kick_reg;

    // latched item
    logic [1:0]                op_mode_reg;
    logic [ctq_pkg::ConnW-1:0] op_conn_reg;
    logic [ctq_pkg::SeqW-1:0]  op_seq_reg;
    logic [ctq_pkg::ExpW-1:0]  op_now_reg;
    logic [ctq_pkg::ExpW-1:0]  op_exp_reg;

    logic [CntW-1:0]           held_reg;
    logic [CntW-1:0]           held_next;
    logic [CntW-1:0]           removed_reg;
    logic [CntW-1:0]           removed_next;
    logic [CntW-1:0]           del_left_reg;
    logic [CntW-1:0]           del_left_next;
    logic                      status_reg;
    logic                      status_next;
    logic [ctq_pkg::CountW-1:0] pop_cnt_reg;
    logic [ctq_pkg::CountW-1:0] pop_cnt_next;
    logic [ctq_pkg::CountW-1:0] limit_reg;
    logic [ctq_pkg::CountW-1:0] emit_ptr_reg;
    logic [ctq_pkg::CountW-1:0] emit_ptr_next;
    logic                      single_reg;
    logic                      single_next;

    logic                      out_valid_reg;
    logic                      exp_valid_reg;
    logic [ctq_pkg::ConnW-1:0] exp_conn_reg;
    logic [ctq_pkg::SeqW-1:0]  exp_seq_reg;
    logic                      status_out_reg;
    logic [ctq_pkg::CountW-1:0] removed_out_reg;
    logic [ctq_pkg::CountW-1:0] count_out_reg;
    logic [ctq_pkg::ExpW-1:0]  earliest_out_reg;
    logic                      last_out_reg;

    logic                      in_accept;
    logic                      out_free;
    logic                      out_load;
    logic                      emit_last;
    logic                      full;
    logic                      pop_go;
    logic                      clear_all;
    logic [32:0]               exp_sum;
    logic [ctq_pkg::ExpW-1:0]  exp_sat;
    logic [ctq_pkg::ConnW-1:0] conn_masked;
    logic [ExtW-1:0]           held_ext;
    logic [ExtW-1:0]           removed_ext;
    logic [ctq_pkg::CountW-1:0] limit_new;

    ctq_pkg::cell_op_t         op;
    ctq_pkg::cell_state_t      cell_state [QUEUE_DEPTH];
    ctq_pkg::cell_link_t       cell_link  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]    used_vec;

    logic                      buf_wr_en;
    logic                      buf_rd_en;
    ctq_pkg::res_t             buf_wr_data;
    ctq_pkg::res_t             buf_rd_data;

    // ---------------- cell row ----------------
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            ctq_pkg::cell_link_t  left_in;
            ctq_pkg::cell_state_t right_in;

            if (gi == 0)
            begin : g_first
                // nothing to the left: behaves as a kept, used entry
                assign left_in.used = 1'b1;
                assign left_in.gt   = 1'b0;
                assign left_in.ent  = '0;
            end
            else
            begin : g_mid_left
                assign left_in = cell_link[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_in.used = 1'b0;
                assign right_in.ent  = '0;
            end
            else
            begin : g_mid_right
                assign right_in = cell_state[gi+1];
            end

            ctq_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (op),
                .clear_all (clear_all),
                .left      (left_in),
                .right     (right_in),
                .state     (cell_state[gi]),
                .link      (cell_link[gi])
            );

            assign used_vec[gi] = cell_state[gi].used;
        end
    endgenerate

    ctq_result_buf u_result_buf
    (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (pop_cnt_reg[ctq_pkg::ResAw-1:0]),
        .wr_data (buf_wr_data),
        .rd_en   (buf_rd_en),
        .rd_addr (emit_ptr_reg[ctq_pkg::ResAw-1:0]),
        .rd_data (buf_rd_data)
    );

    // ---------------- helpers ----------------
    assign in_accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall    = (state_reg != S_IDLE);
    assign out_free    = !out_valid_reg || !out_stall;
    assign exp_sum     = {1'b0, now_time} + {17'b0, wait_time_reg};
    assign exp_sat     = exp_sum[32] ? '1 : exp_sum[ctq_pkg::ExpW-1:0];
    assign conn_masked = conn_id & ConnMaskFull[ctq_pkg::ConnW-1:0];
    assign full        = (held_reg == CntW'(QUEUE_DEPTH));
    assign held_ext    = ExtW'(held_reg);
    assign removed_ext = ExtW'(removed_reg);
    assign limit_new   = (held_ext > ExtW'(ctq_pkg::MaxRes)) ?
                         ctq_pkg::CountW'(ctq_pkg::MaxRes) : held_ext[ctq_pkg::CountW-1:0];
    assign pop_go      = (pop_cnt_reg < limit_reg) && cell_state[0].used &&
                         (cell_state[0].ent.expiry <= op_now_reg);
    assign emit_last   = ((emit_ptr_reg + 7'd1) == pop_cnt_reg);

    assign buf_wr_data.conn = cell_state[0].ent.conn;
    assign buf_wr_data.seq  = cell_state[0].ent.seq;

    // ---------------- control ----------------
    always_comb
    begin
        state_next    = state_reg;
        held_next     = held_reg;
        removed_next  = removed_reg;
        status_next   = status_reg;
        del_left_next = del_left_reg;
        pop_cnt_next  = pop_cnt_reg;
        emit_ptr_next = emit_ptr_reg;
        single_next   = single_reg;
        op            = '0;
        clear_all     = 1'b0;
        buf_wr_en     = 1'b0;
        buf_rd_en     = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    removed_next  = '0;
                    status_next   = 1'b0;
                    pop_cnt_next  = '0;
                    del_left_next = held_reg;
                    single_next   = 1'b1;
                    unique case (mode)
                        ctq_pkg::ModeAdd:    state_next = S_EXEC;
                        ctq_pkg::ModeDelete: state_next = S_DEL;
                        ctq_pkg::ModePoll:   state_next = S_POLL;
                        ctq_pkg::ModeClear:  state_next = S_EXEC;
                        default:             state_next = S_EXEC;
                    endcase
                end
            end

            S_EXEC:
            begin
                if (op_mode_reg == ctq_pkg::ModeAdd)
                begin
                    if (full)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        op.ins         = 1'b1;
                        op.cmp_en      = 1'b1;
                        op.key         = op_exp_reg;
                        op.data.expiry = op_exp_reg;
                        op.data.conn   = op_conn_reg;
                        op.data.seq    = op_seq_reg;
                        held_next      = held_reg + 1'b1;
                    end
                end
                else
                begin
                    clear_all = 1'b1;
                    held_next = '0;
                end
                state_next = S_EMIT;
            end

            S_DEL:
            begin
                // rotate the whole queue once, dropping matching entries
                if (del_left_reg != '0)
                begin
                    op.shift      = 1'b1;
                    op.data       = cell_state[0].ent;
                    del_left_next = del_left_reg - 1'b1;
                    if (cell_state[0].ent.conn != op_conn_reg)
                    begin
                        op.ins = 1'b1;
                    end
                    else
                    begin
                        removed_next = removed_reg + 1'b1;
                        held_next    = held_reg - 1'b1;
                    end
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_POLL:
            begin
                if (pop_go)
                begin
                    op.shift       = 1'b1;
                    op.ins         = !kick_reg;
                    op.cmp_en      = 1'b1;
                    op.key         = op_exp_reg;
                    op.data.expiry = op_exp_reg;
                    op.data.conn   = cell_state[0].ent.conn;
                    op.data.seq    = cell_state[0].ent.seq;
                    buf_wr_en      = 1'b1;
                    pop_cnt_next   = pop_cnt_reg + 1'b1;
                    if (kick_reg)
                    begin
                        held_next = held_reg - 1'b1;
                    end
                end
                else if (pop_cnt_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    single_next   = 1'b0;
                    emit_ptr_next = '0;
                    state_next    = S_FETCH;
                end
            end

            S_FETCH:
            begin
                buf_rd_en  = 1'b1;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (single_reg || emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_ptr_next = emit_ptr_reg + 1'b1;
                        state_next    = S_FETCH;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_time_reg <= ctq_pkg::WaitTimeReset;
            kick_reg      <= 1'b0;
            held_reg      <= '0;
            removed_reg   <= '0;
            status_reg    <= 1'b0;
            del_left_reg  <= '0;
            pop_cnt_reg   <= '0;
            limit_reg     <= '0;
            emit_ptr_reg  <= '0;
            single_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            removed_reg  <= removed_next;
            status_reg   <= status_next;
            del_left_reg <= del_left_next;
            pop_cnt_reg  <= pop_cnt_next;
            emit_ptr_reg <= emit_ptr_next;
            single_reg   <= single_next;
            if (in_accept)
            begin
                limit_reg <= limit_new;
            end
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    ctq_pkg::CfgWaitTime: wait_time_reg <= cfg_data;
                    ctq_pkg::CfgKick:     kick_reg      <= cfg_data[0];
                    default:              kick_reg      <= kick_reg;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_mode_reg <= mode;
            op_conn_reg <= conn_masked;
            op_seq_reg  <= seq_num;
            op_now_reg  <= now_time;
            op_exp_reg  <= exp_sat;
        end
        if (out_load)
        begin
            exp_valid_reg    <= !single_reg;
            exp_conn_reg     <= single_reg ? '0 : buf_rd_data.conn;
            exp_seq_reg      <= single_reg ? '0 : buf_rd_data.seq;
            status_out_reg   <= status_reg;
            removed_out_reg  <= removed_ext[ctq_pkg::CountW-1:0];
            count_out_reg    <= held_ext[ctq_pkg::CountW-1:0];
            earliest_out_reg <= cell_state[0].used ? cell_state[0].ent.expiry : '0;
            last_out_reg     <= single_reg || emit_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign expired_valid   = exp_valid_reg;
    assign expired_conn    = exp_conn_reg;
    assign expired_seq     = exp_seq_reg;
    assign status          = status_out_reg;
    assign removed_count   = removed_out_reg;
    assign entry_count     = count_out_reg;
    assign earliest_expiry = earliest_out_reg;
    assign last            = last_out_reg;

`ifndef NO_ASSERTIONS
    // occupied cells always form the counted set
    a_count_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_vec) == held_reg)
        else $error("held count disagrees with occupied cells");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CntW'(QUEUE_DEPTH))
        else $error("held count beyond depth");

    a_pop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pop_cnt_reg <= limit_reg)
        else $error("poll popped past its limit");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

FILE: tb/sv/connection_timeout_queue_tb.sv
// connection_timeout_queue_tb: self-checking bench for the connection timeout queue.
// Mirrors the sorted timer store, drives directed and random add/delete/poll/clear
// traffic with random idling, and checks every result beat. Depends on ctq_pkg.
`timescale 1ns / 100ps

module connection_timeout_queue_tb;

    localparam int Depth        = 64;
    localparam int StallLimit   = 5000;
    localparam int SettleCycles = 8;

    typedef struct packed {
        logic                       ev;
        logic [ctq_pkg::ConnW-1:0]  conn;
        logic [ctq_pkg::SeqW-1:0]   seq;
        logic                       st;
        logic [ctq_pkg::CountW-1:0] removed;
        logic [ctq_pkg::CountW-1:0] held;
        logic [ctq_pkg::ExpW-1:0]   head;
        logic                       fin;
    } expiry_beat_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic                       cfg_index;
    logic [ctq_pkg::WaitW-1:0]  cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 mode;
    logic [ctq_pkg::ConnW-1:0]  conn_id;
    logic [ctq_pkg::SeqW-1:0]   seq_num;
    logic [ctq_pkg::ExpW-1:0]   now_time;
    logic                       out_valid;
    logic                       out_stall;
    logic                       expired_valid;
    logic [ctq_pkg::ConnW-1:0]  expired_conn;
    logic [ctq_pkg::SeqW-1:0]   expired_seq;
    logic                       status;
    logic [ctq_pkg::CountW-1:0] removed_count;
    logic [ctq_pkg::CountW-1:0] entry_count;
    logic [ctq_pkg::ExpW-1:0]   earliest_expiry;
    logic                       last;

    // mirror of the timer store
    logic [ctq_pkg::ExpW-1:0]   mirror_expiry [Depth];
    logic [ctq_pkg::ConnW-1:0]  mirror_conn [Depth];
    logic [ctq_pkg::SeqW-1:0]   mirror_seq [Depth];
    int                         mirror_held;
    logic [ctq_pkg::WaitW-1:0]  mirror_wait;
    logic                       mirror_kick;

    expiry_beat_t               awaited_beats [$];
    expiry_beat_t               seen_beat;
    expiry_beat_t               want_beat;

    bit                         quiet;
    logic [ctq_pkg::ExpW-1:0]   wall_clock;
    int                         mismatches;
    int                         idle_cycles;
    int                         items_taken;
    int                         beats_checked;
    int                         entries_popped;
    int                         adds_refused;
    int                         deepest_poll;

    connection_timeout_queue dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .conn_id         (conn_id),
        .seq_num         (seq_num),
        .now_time        (now_time),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .expired_valid   (expired_valid),
        .expired_conn    (expired_conn),
        .expired_seq     (expired_seq),
        .status          (status),
        .removed_count   (removed_count),
        .entry_count     (entry_count),
        .earliest_expiry (earliest_expiry),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // expiry = now + wait_time, saturating at all ones
    function automatic logic [ctq_pkg::ExpW-1:0] expiry_from(
        input logic [ctq_pkg::ExpW-1:0] now);
        logic [ctq_pkg::ExpW:0] sum;
        sum = {1'b0, now} + {{(ctq_pkg::ExpW + 1 - ctq_pkg::WaitW){1'b0}}, mirror_wait};
        return sum[ctq_pkg::ExpW] ? '1 : sum[ctq_pkg::ExpW-1:0];
    endfunction

    function automatic bit mirror_insert(input logic [ctq_pkg::ExpW-1:0] ex,
                                         input logic [ctq_pkg::ConnW-1:0] c,
                                         input logic [ctq_pkg::SeqW-1:0] s);
        int pos;
        int i;
        if (mirror_held >= Depth)
            return 1'b0;
        pos = 0;
        // equal expiries stay in insertion order
        while (pos < mirror_held && mirror_expiry[pos] <= ex)
            pos++;
        for (i = mirror_held; i > pos; i--)
        begin
            mirror_expiry[i] = mirror_expiry[i-1];
            mirror_conn[i]   = mirror_conn[i-1];
            mirror_seq[i]    = mirror_seq[i-1];
        end
        mirror_expiry[pos] = ex;
        mirror_conn[pos]   = c;
        mirror_seq[pos]    = s;
        mirror_held++;
        return 1'b1;
    endfunction

    function automatic void predict_timer_item(input logic [1:0] md,
                                               input logic [ctq_pkg::ConnW-1:0] cid,
                                               input logic [ctq_pkg::SeqW-1:0] sq,
                                               input logic [ctq_pkg::ExpW-1:0] nt);
        expiry_beat_t beats [$];
        expiry_beat_t b;
        int kept;
        int gone;
        int bound;
        int i;
        logic [ctq_pkg::ConnW-1:0] pc;
        logic [ctq_pkg::SeqW-1:0] ps;
        b = '0;
        case (md)
            ctq_pkg::ModeAdd:
            begin
                b.st = !mirror_insert(expiry_from(nt), cid, sq);
                if (b.st)
                    adds_refused++;
                beats.insert(beats.size(), b);
            end
            ctq_pkg::ModeDelete:
            begin
                kept = 0;
                gone = 0;
                for (i = 0; i < mirror_held; i++)
                begin
                    if (mirror_conn[i] == cid)
                        gone++;
                    else
                    begin
                        mirror_expiry[kept] = mirror_expiry[i];
                        mirror_conn[kept]   = mirror_conn[i];
                        mirror_seq[kept]    = mirror_seq[i];
                        kept++;
                    end
                end
                mirror_held = kept;
                b.removed = gone[ctq_pkg::CountW-1:0];
                beats.insert(beats.size(), b);
            end
            ctq_pkg::ModePoll:
            begin
                // bounded by the count at the start, so re-armed entries pop once
                bound = (mirror_held > ctq_pkg::MaxRes) ? ctq_pkg::MaxRes : mirror_held;
                while (beats.size() < bound && mirror_held > 0 && mirror_expiry[0] <= nt)
                begin
                    pc = mirror_conn[0];
                    ps = mirror_seq[0];
                    for (i = 1; i < mirror_held; i++)
                    begin
                        mirror_expiry[i-1] = mirror_expiry[i];
                        mirror_conn[i-1]   = mirror_conn[i];
                        mirror_seq[i-1]    = mirror_seq[i];
                    end
                    mirror_held--;
                    if (!mirror_kick)
                        void'(mirror_insert(expiry_from(nt), pc, ps));
                    b = '0;
                    b.ev   = 1'b1;
                    b.conn = pc;
                    b.seq  = ps;
                    beats.insert(beats.size(), b);
                end
                entries_popped += beats.size();
                if (beats.size() > deepest_poll)
                    deepest_poll = beats.size();
                if (beats.size() == 0)
                begin
                    b = '0;
                    beats.insert(beats.size(), b);
                end
            end
            default:
            begin
                mirror_held = 0;
                beats.insert(beats.size(), b);
            end
        endcase
        foreach (beats[k])
        begin
            beats[k].held = mirror_held[ctq_pkg::CountW-1:0];
            beats[k].head = (mirror_held > 0) ? mirror_expiry[0] : '0;
            beats[k].fin  = (k == beats.size() - 1);
            awaited_beats.insert(awaited_beats.size(), beats[k]);
        end
    endfunction

    task automatic check_beat(input expiry_beat_t got);
        beats_checked++;
        if (awaited_beats.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected result beat at %0t", $realtime);
                $display("  got v=%0b c=%h s=%h st=%0b rm=%0d n=%0d hd=%h l=%0b",
                         got.ev, got.conn, got.seq, got.st, got.removed, got.held,
                         got.head, got.fin);
            end
            return;
        end
        want_beat = awaited_beats[0];
        awaited_beats.delete(0);
        if (got !== want_beat)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("beat %0d mismatch at %0t", beats_checked, $realtime);
                $display("  exp v=%0b c=%h s=%h st=%0b rm=%0d n=%0d hd=%h l=%0b",
                         want_beat.ev, want_beat.conn, want_beat.seq, want_beat.st,
                         want_beat.removed, want_beat.held, want_beat.head, want_beat.fin);
                $display("  got v=%0b c=%h s=%h st=%0b rm=%0d n=%0d hd=%h l=%0b",
                         got.ev, got.conn, got.seq, got.st, got.removed, got.held,
                         got.head, got.fin);
            end
        end
    endtask

    // results are checked before the beat taken at the same edge is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (out_valid && !out_stall)
            begin
                seen_beat.ev      = expired_valid;
                seen_beat.conn    = expired_conn;
                seen_beat.seq     = expired_seq;
                seen_beat.st      = status;
                seen_beat.removed = removed_count;
                seen_beat.held    = entry_count;
                seen_beat.head    = earliest_expiry;
                seen_beat.fin     = last;
                check_beat(seen_beat);
                idle_cycles = 0;
            end
            if (in_valid && !in_stall)
            begin
                predict_timer_item(mode, conn_id, seq_num, now_time);
                items_taken++;
                idle_cycles = 0;
            end
            if (idle_cycles >= StallLimit)
            begin
                $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                         idle_cycles, awaited_beats.size());
                $display("connection_timeout_queue_tb NOT OK");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < 34);
    end

    task automatic send_item(input logic [1:0] md, input logic [ctq_pkg::ConnW-1:0] cid,
                             input logic [ctq_pkg::SeqW-1:0] sq,
                             input logic [ctq_pkg::ExpW-1:0] nt);
        while (!quiet && $urandom_range(99) < 34)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        mode     <= md;
        conn_id  <= cid;
        seq_num  <= sq;
        now_time <= nt;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_beats.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [ctq_pkg::WaitW-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == ctq_pkg::CfgWaitTime)
            mirror_wait = value;
        else
            mirror_kick = value[0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic [ctq_pkg::WaitW-1:0] wt, input logic kick);
        drain();
        write_reg(ctq_pkg::CfgWaitTime, wt);
        write_reg(ctq_pkg::CfgKick, {{(ctq_pkg::WaitW - 1){1'b0}}, kick});
    endtask

    // reset values: wait 30, re-arm on expiry
    task automatic test_basic_ops;
        send_item(ctq_pkg::ModePoll, '0, '0, '0);
        send_item(ctq_pkg::ModeDelete, 10'd7, '0, '0);
        send_item(ctq_pkg::ModeAdd, 10'd0, 32'h0, 32'h0);
        send_item(ctq_pkg::ModeAdd, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(ctq_pkg::ModeAdd, 10'd5, 32'h5555_AAAA, 32'h0);   // ties the first add
        send_item(ctq_pkg::ModeAdd, 10'd5, 32'hAAAA_5555, 32'd10);
        send_item(ctq_pkg::ModePoll, '0, '0, 32'd29);
        send_item(ctq_pkg::ModePoll, '0, '0, 32'd30);
        send_item(ctq_pkg::ModeDelete, 10'd5, '0, '0);
        send_item(ctq_pkg::ModePoll, '0, '0, 32'hFFFF_FFFF);
        send_item(ctq_pkg::ModeClear, 10'h2AA, 32'h1234_5678, 32'h8765_4321);
        send_item(ctq_pkg::ModePoll, '0, '0, 32'hFFFF_FFFF);
    endtask

    // saturated expiries, poll bound on re-arm, then drop on expiry
    task automatic test_config_extremes;
        set_config(16'hFFFF, 1'b0);
        send_item(ctq_pkg::ModeAdd, 10'd3, 32'd1, 32'hFFFF_0000);
        send_item(ctq_pkg::ModeAdd, 10'd4, 32'd2, 32'hFFFF_0001);
        send_item(ctq_pkg::ModePoll, '0, '0, 32'hFFFF_FFFF);
        send_item(ctq_pkg::ModePoll, '0, '0, 32'hFFFF_FFFF);
        set_config(16'd1, 1'b1);
        send_item(ctq_pkg::ModeAdd, 10'd9, 32'hDEAD_BEEF, 32'h0);
        send_item(ctq_pkg::ModePoll, '0, '0, 32'h0);
        send_item(ctq_pkg::ModePoll, '0, '0, 32'h1);
        send_item(ctq_pkg::ModeDelete, 10'd3, '0, '0);
        send_item(ctq_pkg::ModePoll, '0, '0, 32'hFFFF_FFFF);
        send_item(ctq_pkg::ModeClear, '0, '0, '0);
    endtask

    // fill past capacity, then pop a full store twice
    task automatic test_full_store;
        int n;
        set_config(16'($urandom_range(1, 100)), 1'b0);
        send_item(ctq_pkg::ModeClear, '0, '0, '0);
        for (n = 0; n < Depth + 6; n++)
            send_item(ctq_pkg::ModeAdd, 10'($urandom_range(0, 15)), $urandom,
                      32'd1000 + $urandom_range(0, 50));
        send_item(ctq_pkg::ModePoll, '0, '0, 32'hFFFF_FFFF);
        set_config(mirror_wait, 1'b1);
        send_item(ctq_pkg::ModePoll, '0, '0, 32'hFFFF_FFFF);
        send_item(ctq_pkg::ModeDelete, 10'($urandom_range(0, 15)), '0, '0);
    endtask

    task automatic test_random_traffic(input int count,
                                       input logic [ctq_pkg::WaitW-1:0] wt,
                                       input logic kick, input bit calm,
                                       input logic [ctq_pkg::ExpW-1:0] start);
        int n;
        int r;
        logic [ctq_pkg::ConnW-1:0] cid;
        logic [ctq_pkg::ExpW:0] next_now;
        set_config(wt, kick);
        quiet = calm;
        wall_clock = start;
        for (n = 0; n < count; n++)
        begin
            next_now = {1'b0, wall_clock} + {1'b0, $urandom_range(0, wt / 3 + 1)};
            wall_clock = next_now[ctq_pkg::ExpW] ? '1 : next_now[ctq_pkg::ExpW-1:0];
            cid = ($urandom_range(3) != 0) ? 10'($urandom_range(0, 7)) :
                                             10'($urandom_range(0, 1023));
            r = $urandom_range(99);
            if (r < 45)
                send_item(ctq_pkg::ModeAdd, cid, $urandom, wall_clock);
            else if (r < 75)
                send_item(ctq_pkg::ModePoll, 10'($urandom), $urandom, wall_clock);
            else if (r < 92)
                send_item(ctq_pkg::ModeDelete, cid, $urandom, $urandom);
            else if (r < 95)
                send_item(ctq_pkg::ModeClear, 10'($urandom), $urandom, $urandom);
            else
                send_item(2'($urandom_range(0, 3)), 10'($urandom), $urandom, $urandom);
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = ctq_pkg::CfgWaitTime;
        cfg_data       = '0;
        in_valid       = 1'b0;
        mode           = ctq_pkg::ModeAdd;
        conn_id        = '0;
        seq_num        = '0;
        now_time       = '0;
        out_stall      = 1'b0;
        quiet          = 1'b0;
        wall_clock     = '0;
        mirror_held    = 0;
        mirror_wait    = ctq_pkg::WaitTimeReset;
        mirror_kick    = 1'b0;
        mismatches     = 0;
        idle_cycles    = 0;
        items_taken    = 0;
        beats_checked  = 0;
        entries_popped = 0;
        adds_refused   = 0;
        deepest_poll   = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_ops();
        test_config_extremes();
        test_full_store();
        test_random_traffic(90, 16'd30, 1'b0, 1'b0, 32'd0);
        test_random_traffic(90, 16'd1, 1'b1, 1'b1, 32'h0001_0000);
        test_random_traffic(90, 16'hFFFF, 1'b0, 1'b0, 32'hFFF0_0000);
        test_random_traffic(90, 16'($urandom_range(2, 500)), 1'($urandom_range(0, 1)),
                            1'b0, $urandom);
        drain();

        if (awaited_beats.size() != 0)
        begin
            mismatches++;
            $display("%0d expected result beats never arrived", awaited_beats.size());
        end
        $display("%0d items in, %0d result beats checked", items_taken, beats_checked);
        $display("%0d entries expired, deepest poll %0d, %0d adds refused, %0d mismatches",
                 entries_popped, deepest_poll, adds_refused, mismatches);
        if (mismatches == 0)
            $display("connection_timeout_queue_tb OK");
        else
            $display("connection_timeout_queue_tb NOT OK");
        $finish;
    end

endmodule
